/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL. They compile to nothing in synthesis.
// All users must have a clock named clk and an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SFR_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("sfr assertion failed");
`define SFR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfr assertion failed");
`else
`define SFR_ASSERT(label, expr)
`define SFR_ASSERT_IMP(label, ante, cons)
`endif
`endif

/* rtl/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the stream find-and-replace unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  localparam int LEN_W      = 4;
  localparam int PAT_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_PAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_LEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_PAT  = 2'd3;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_valid;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       run_last;
    logic       text_done;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_END,
    CMD_BYTE_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PLAN,
    ST_EMIT
  } back_state_t;

endpackage

`default_nettype wire

/* rtl/stream_find_replace_unit.sv */
// ----------------------------------------------------------------------------
// stream_find_replace_unit
// Streaming find-and-replace-all over a byte text with a configurable
// pattern and replacement of up to MAX_LEN bytes each.
// ----------------------------------------------------------------------------
// Each accepted request passes through the back end's command take and
// planning and then an emit step for every result it causes. The back-end
// sequencer puts one byte per cycle into the output register while that
// register is empty or being popped, and stalls otherwise. A two-entry
// command queue lets the input side run ahead while results are still being
// emitted, and the output register is refilled in the same cycle that the
// current result is popped. Configuration may only be written while no text
// is in flight.
`default_nettype none

module stream_find_replace_unit #(
  parameter int MAX_LEN = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  sfr_pkg::in_item_t                    in_item,
  input  logic                                 in_push,
  output logic                                 in_full,
  output sfr_pkg::out_item_t                   out_item,
  output logic                                 out_empty,
  input  logic                                 out_pop
);
  import sfr_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic [LEN_W-1:0]   match_length_r;
  logic [PAT_W-1:0]   match_pattern_r;
  logic [LEN_W-1:0]   replace_length_r;
  logic [PAT_W-1:0]   replace_pattern_r;
  logic [CNT_W-1:0]   mlen, rlen;

  logic               q_push, q_full, q_pop, q_empty;
  cmd_t               q_cmd_in, q_cmd_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_length_r    <= '0;
      match_pattern_r   <= '0;
      replace_length_r  <= '0;
      replace_pattern_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATCH_LEN: match_length_r    <= cfg_data[LEN_W-1:0];
        REG_MATCH_PAT: match_pattern_r   <= cfg_data[PAT_W-1:0];
        REG_REPL_LEN:  replace_length_r  <= cfg_data[LEN_W-1:0];
        REG_REPL_PAT:  replace_pattern_r <= cfg_data[PAT_W-1:0];
        default: begin
          match_length_r <= match_length_r;
        end
      endcase
    end
  end

  // Lengths above the window size behave as the window size.
  always_comb begin
    mlen = (match_length_r > LEN_W'(MAX_LEN)) ? CNT_W'(MAX_LEN)
                                               : match_length_r[CNT_W-1:0];
    rlen = (replace_length_r > LEN_W'(MAX_LEN)) ? CNT_W'(MAX_LEN)
                                                 : replace_length_r[CNT_W-1:0];
  end

  sfr_front u_front (
    .in_item (in_item),
    .in_push (in_push),
    .in_full (in_full),
    .q_push  (q_push),
    .q_cmd   (q_cmd_in),
    .q_full  (q_full)
  );

  sfr_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .cmd_in  (q_cmd_in),
    .full    (q_full),
    .pop     (q_pop),
    .cmd_out (q_cmd_out),
    .empty   (q_empty)
  );

  sfr_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (q_cmd_out),
    .cmd_empty       (q_empty),
    .cmd_pop         (q_pop),
    .mlen            (mlen),
    .rlen            (rlen),
    .match_pattern   (match_pattern_r[8*MAX_LEN-1:0]),
    .replace_pattern (replace_pattern_r[8*MAX_LEN-1:0]),
    .out_item        (out_item),
    .out_empty       (out_empty),
    .out_pop         (out_pop)
  );

endmodule

`default_nettype wire

/* rtl/sfr_front.sv */
// ----------------------------------------------------------------------------
// sfr_front
// Accepts input requests, classifies them into commands and drops requests
// that carry neither a byte nor an end marker.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_front (
  input  sfr_pkg::in_item_t in_item,
  input  logic              in_push,
  output logic              in_full,
  output logic              q_push,
  output sfr_pkg::cmd_t     q_cmd,
  input  logic              q_full
);
  import sfr_pkg::*;

  logic keep;
  logic accept;

  always_comb begin
    keep       = 1'b1;
    q_cmd.data = in_item.text_byte;
    case ({in_item.text_valid, in_item.end_of_text})
      2'b10: begin
        q_cmd.kind = CMD_BYTE;
      end
      2'b01: begin
        q_cmd.kind = CMD_END;
      end
      2'b11: begin
        q_cmd.kind = CMD_BYTE_END;
      end
      default: begin
        q_cmd.kind = CMD_BYTE;
        keep       = 1'b0;
      end
    endcase
  end

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign q_push  = accept && keep;

endmodule

`default_nettype wire

/* rtl/sfr_cmd_queue.sv */
// ----------------------------------------------------------------------------
// sfr_cmd_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sfr_pkg::cmd_t cmd_in,
  output logic          full,
  input  logic          pop,
  output sfr_pkg::cmd_t cmd_out,
  output logic          empty
);
  import sfr_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign cmd_out = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

/* rtl/sfr_back.sv */
// ----------------------------------------------------------------------------
// sfr_back
// Holds the pending window, plans the results of one command and emits them
// one byte per cycle into the output register while it is empty or popped.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sfr_back #(
  parameter  int MAX_LEN = 8,
  localparam int CNT_W   = $clog2(MAX_LEN + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sfr_pkg::cmd_t          cmd,
  input  logic                   cmd_empty,
  output logic                   cmd_pop,
  input  logic [CNT_W-1:0]       mlen,
  input  logic [CNT_W-1:0]       rlen,
  input  logic [8*MAX_LEN-1:0]   match_pattern,
  input  logic [8*MAX_LEN-1:0]   replace_pattern,
  output sfr_pkg::out_item_t     out_item,
  output logic                   out_empty,
  input  logic                   out_pop
);
  import sfr_pkg::*;

  back_state_t          state_r, state_nxt;
  logic [7:0]           win_r [MAX_LEN];
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     wleft_r, wleft_nxt;
  logic [CNT_W-1:0]     rleft_r, rleft_nxt;
  logic                 marker_r, marker_nxt;
  logic                 has_byte_r, end_r, pass_r;
  logic [8*MAX_LEN-1:0] rep_sr_r;
  logic                 out_full_r, out_full_nxt;
  out_item_t            out_item_r;

  logic                 cmd_has_byte, cmd_is_end;
  logic                 take;
  logic [MAX_LEN:0]     pfx;
  logic [CNT_W-1:0]     k;
  logic                 scan, match;
  logic [CNT_W-1:0]     n_win, n_rep;
  logic                 out_load, out_taken, emit_last;
  logic                 shift_win, shift_rep;
  out_item_t            emit_item;

  always_comb begin
    case (cmd.kind)
      CMD_BYTE: begin
        cmd_has_byte = 1'b1;
        cmd_is_end   = 1'b0;
      end
      CMD_END: begin
        cmd_has_byte = 1'b0;
        cmd_is_end   = 1'b1;
      end
      CMD_BYTE_END: begin
        cmd_has_byte = 1'b1;
        cmd_is_end   = 1'b1;
      end
      default: begin
        cmd_has_byte = 1'b0;
        cmd_is_end   = 1'b0;
      end
    endcase
  end

  assign take    = (state_r == ST_IDLE) && !cmd_empty;
  assign cmd_pop = take;

  // pfx[s] is set when the window with its first s bytes dropped is still a
  // prefix of the pattern; k is the fewest bytes that must leave the front.
  always_comb begin
    for (int s = 0; s <= MAX_LEN; s++) begin
      pfx[s] = (CNT_W'(s) <= cnt_r) && ((cnt_r - CNT_W'(s)) <= mlen);
      for (int j = s; j < MAX_LEN; j++) begin
        if ((CNT_W'(j) < cnt_r) && (win_r[j] != match_pattern[8*(j-s) +: 8])) begin
          pfx[s] = 1'b0;
        end
      end
    end
    k = CNT_W'(MAX_LEN);
    for (int s = MAX_LEN; s >= 0; s--) begin
      if (pfx[s]) begin
        k = CNT_W'(s);
      end
    end
  end

  // A full match must cover the whole window, so it needs k of 0 and a window as long as the pattern.
  always_comb begin
    scan  = has_byte_r && !pass_r;
    match = scan && (k == '0) && (cnt_r == mlen);
    n_win = match ? '0 : ((scan && !end_r) ? k : cnt_r);
    n_rep = match ? rlen : '0;
  end

  assign out_taken = out_pop && out_full_r;
  assign out_load  = (state_r == ST_EMIT) && (!out_full_r || out_pop);
  assign out_empty = !out_full_r;
  assign out_item  = out_item_r;

  always_comb begin
    emit_item = '0;
    shift_win = 1'b0;
    shift_rep = 1'b0;
    if (wleft_r != '0) begin
      emit_item.out_byte  = win_r[0];
      emit_item.out_valid = 1'b1;
      emit_last           = (wleft_r == CNT_W'(1)) && (rleft_r == '0);
      shift_win           = out_load;
    end else if (rleft_r != '0) begin
      emit_item.out_byte  = rep_sr_r[7:0];
      emit_item.out_valid = 1'b1;
      emit_last           = (rleft_r == CNT_W'(1));
      shift_rep           = out_load;
    end else begin
      emit_last = 1'b1;
    end
    emit_item.run_last  = emit_last;
    emit_item.text_done = emit_last && end_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          state_nxt = ST_PLAN;
        end
      end
      ST_PLAN: begin
        if ((n_win != '0) || (n_rep != '0) || end_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_load && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    wleft_nxt  = wleft_r;
    rleft_nxt  = rleft_r;
    marker_nxt = marker_r;
    case (state_r)
      ST_IDLE: begin
        if (take && cmd_has_byte) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_PLAN: begin
        wleft_nxt  = n_win;
        rleft_nxt  = n_rep;
        marker_nxt = end_r && (n_win == '0) && (n_rep == '0);
        if (match) begin
          cnt_nxt = '0;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          if (wleft_r != '0) begin
            wleft_nxt = wleft_r - CNT_W'(1);
            cnt_nxt   = cnt_r - CNT_W'(1);
          end else if (rleft_r != '0) begin
            rleft_nxt = rleft_r - CNT_W'(1);
          end else begin
            marker_nxt = 1'b0;
          end
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_full_nxt = 1'b1;
    end else if (out_taken) begin
      out_full_nxt = 1'b0;
    end else begin
      out_full_nxt = out_full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      wleft_r    <= '0;
      rleft_r    <= '0;
      marker_r   <= 1'b0;
      out_full_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      wleft_r    <= wleft_nxt;
      rleft_r    <= rleft_nxt;
      marker_r   <= marker_nxt;
      out_full_r <= out_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      has_byte_r <= cmd_has_byte;
      end_r      <= cmd_is_end;
      pass_r     <= cmd_has_byte && (({1'b0, cnt_r} + 1'b1) > {1'b0, mlen});
      for (int i = 0; i < MAX_LEN; i++) begin
        if (cmd_has_byte && (cnt_r == CNT_W'(i))) begin
          win_r[i] <= cmd.data;
        end
      end
    end
    if (shift_win) begin
      for (int i = 0; i < MAX_LEN - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
    end
    if (state_r == ST_PLAN) begin
      rep_sr_r <= replace_pattern;
    end else if (shift_rep) begin
      rep_sr_r <= rep_sr_r >> 8;
    end
    if (out_load) begin
      out_item_r <= emit_item;
    end
  end

  `SFR_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(MAX_LEN))
  `SFR_ASSERT_IMP(a_idle_window, state_r == ST_IDLE, cnt_r < CNT_W'(MAX_LEN))
  `SFR_ASSERT_IMP(a_idle_clear, state_r == ST_IDLE, (wleft_r == '0) && (rleft_r == '0) && !marker_r)
  `SFR_ASSERT_IMP(a_emit_window, (state_r == ST_EMIT) && (wleft_r != '0), wleft_r <= cnt_r)

endmodule

`default_nettype wire
